/* rtl/median_of_loaded_set_top_defines.svh */
// Assertion macros shared by the median block's RTL files.
// Depends on nothing; included by the modules that carry assertions.
`ifndef MEDIAN_OF_LOADED_SET_TOP_DEFINES_SVH
`define MEDIAN_OF_LOADED_SET_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MOLS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("median block assertion failed");
`define MOLS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("median block assertion failed");
`else
`define MOLS_ASSERT(lbl, clk, rst_n, prop)
`define MOLS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* rtl/mols_pkg.sv */
// Shared widths, defaults and controller/datapath command and status types
// for the median block. Depends on nothing.
package mols_pkg;

    localparam int VAL_W            = 32;
    localparam int MED_W            = 33;
    localparam int CNT_OUT_W        = 9;
    localparam int MAX_ELEMENTS_DEF = 256;

    typedef struct packed {
        logic accept;
        logic rd_prev;
        logic shift;
        logic place;
        logic rd_hi;
        logic cap_hi;
        logic rd_lo;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic pos_zero;
        logic greater;
        logic last;
        logic out_busy;
    } t_stat;

endpackage

/* rtl/mols_if.sv */
// Valid/ready stream interfaces for the input and result channels.
// Depends on mols_pkg for the field widths.
interface mols_in_if;
    logic                        valid;
    logic                        ready;
    logic [mols_pkg::VAL_W-1:0]  sample_value;
    logic                        last_of_set;

    modport source (output valid, output sample_value, output last_of_set, input ready);
    modport sink (input valid, input sample_value, input last_of_set, output ready);
endinterface

interface mols_out_if;
    logic                            valid;
    logic                            ready;
    logic [mols_pkg::MED_W-1:0]      median_doubled;
    logic [mols_pkg::CNT_OUT_W-1:0]  element_count;
    logic                            overflowed;

    modport source (output valid, output median_doubled, output element_count,
                    output overflowed, input ready);
    modport sink (input valid, input median_doubled, input element_count,
                  input overflowed, output ready);
endinterface

/* rtl/median_of_loaded_set_top.sv */
// Median of a loaded set: signed elements are insertion-sorted into a memory
// and, when the set closes, twice the median is delivered with the count.
//
// Input channel i_in: one transaction per element, sample_value and
// last_of_set; the transaction with last_of_set high closes the set.
// Output channel o_out: one transaction per set, median_doubled (exact,
// 33-bit two's complement), element_count and overflowed.
// Transactions are handled one at a time. The walk goes down from the top
// of the stored elements, shifting each one greater than the new one up a
// place, then places the new one above the first that is not greater, or at
// the bottom; entries are read and shifted one at a time through the single
// read and single write port, and the next element is accepted after that.
// Elements arriving when MAX_ELEMENTS are held are dropped and flag
// overflowed. After the closing element is stored or dropped, the median
// read-out (S_MED0 to S_MED2) reads the middle entries before the result is
// registered on o_out, and the next set's first element is accepted from that cycle on.
// Reset clears the count, drop flag and result valid and holds i_in.ready
// low; the memory holds no reset value. If the receiver stalls, the result
// is held and loading of the next set carries on; only the next result waits.
module median_of_loaded_set_top #(
    parameter int MAX_ELEMENTS = mols_pkg::MAX_ELEMENTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mols_in_if.sink    i_in,
    mols_out_if.source o_out
);
    import mols_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    assign i_in.ready = in_ready;

    mols_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mols_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_sample_value (i_in.sample_value),
        .i_last_of_set  (i_in.last_of_set),
        .o_out          (o_out)
    );
endmodule

/* rtl/mols_datapath.sv */
// Datapath of the median block: sorted element memory, insertion pointer,
// count, drop flag and the result register. Depends on mols_pkg and mols_if.
`include "median_of_loaded_set_top_defines.svh"
module mols_datapath #(
    parameter int MAX_ELEMENTS = mols_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mols_pkg::t_cmd             i_cmd,
    output mols_pkg::t_stat            o_stat,
    input  logic [mols_pkg::VAL_W-1:0] i_sample_value,
    input  logic                       i_last_of_set,
    mols_out_if.source                 o_out
);
    import mols_pkg::*;

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    logic signed [VAL_W-1:0] r_mem [MAX_ELEMENTS];
    logic signed [VAL_W-1:0] r_val;
    logic signed [VAL_W-1:0] r_rdata;
    logic signed [VAL_W-1:0] r_hi;
    logic                    r_last;
    logic [AW-1:0]           r_pos;
    logic [CW-1:0]           r_count;
    logic                    r_drop;
    logic                    r_out_valid;
    logic [MED_W-1:0]        r_median;
    logic [CNT_OUT_W-1:0]    r_out_count;
    logic                    r_out_ovf;

    logic                    full;
    logic [AW-1:0]           mid;
    logic [AW-1:0]           rd_addr;
    logic signed [MED_W-1:0] hi_x;
    logic signed [MED_W-1:0] lo_x;
    logic signed [MED_W-1:0] n_median;
    logic [31:0]             count_ext;

    assign full      = (r_count == CW'(MAX_ELEMENTS));
    assign mid       = AW'(r_count >> 1);
    assign hi_x      = {r_hi[VAL_W-1], r_hi};
    assign lo_x      = {r_rdata[VAL_W-1], r_rdata};
    assign n_median  = r_count[0] ? (hi_x + hi_x) : (hi_x + lo_x);
    assign count_ext = 32'(r_count);

    always_comb begin
        priority if (i_cmd.rd_prev) begin
            rd_addr = r_pos - AW'(1);
        end else if (i_cmd.rd_lo) begin
            rd_addr = mid - AW'(1);
        end else begin
            rd_addr = mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_mem[r_pos] <= r_rdata;
        end else if (i_cmd.place) begin
            r_mem[r_pos] <= r_val;
        end
        if (i_cmd.rd_prev || i_cmd.rd_hi || i_cmd.rd_lo) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_val  <= i_sample_value;
            r_last <= i_last_of_set;
        end
        if (i_cmd.cap_hi) begin
            r_hi <= r_rdata;
        end
        if (i_cmd.finish) begin
            r_median    <= n_median;
            r_out_count <= count_ext[CNT_OUT_W-1:0];
            r_out_ovf   <= r_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_pos <= r_count[AW-1:0];
                if (full) begin
                    r_drop <= 1'b1;
                end
            end else if (i_cmd.shift) begin
                r_pos <= r_pos - AW'(1);
            end
            if (i_cmd.place) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.finish) begin
                r_count     <= '0;
                r_drop      <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.full     = full;
    assign o_stat.pos_zero = (r_pos == '0);
    assign o_stat.greater  = (r_rdata > r_val);
    assign o_stat.last     = r_last;
    assign o_stat.out_busy = r_out_valid;

    assign o_out.valid          = r_out_valid;
    assign o_out.median_doubled = r_median;
    assign o_out.element_count  = r_out_count;
    assign o_out.overflowed     = r_out_ovf;

    `MOLS_ASSERT(a_shift_not_at_bottom, i_clk, i_rst_n, i_cmd.shift |-> (r_pos != '0))
    `MOLS_ASSERT(a_finish_slot_free, i_clk, i_rst_n, i_cmd.finish |-> !r_out_valid)
    `MOLS_ASSERT(a_finish_clears, i_clk, i_rst_n, i_cmd.finish |=> (r_count == '0 && !r_drop))
    `MOLS_ASSERT(a_full_drops, i_clk, i_rst_n, (i_cmd.accept && full) |=> r_drop)
endmodule

/* rtl/mols_ctrl.sv */
// Controller of the median block: sequences insertion steps and the median
// read-out through command and status structs. Depends on mols_pkg.
`include "median_of_loaded_set_top_defines.svh"
module mols_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  mols_pkg::t_stat i_stat,
    output mols_pkg::t_cmd  o_cmd
);
    import mols_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SCAN = 7'b0000010,
        S_CMP  = 7'b0000100,
        S_DONE = 7'b0001000,
        S_MED0 = 7'b0010000,
        S_MED1 = 7'b0100000,
        S_MED2 = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = i_rst_n && (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_stat.full ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.pos_zero) begin
                    o_cmd.place = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    o_cmd.rd_prev = 1'b1;
                    n_state       = S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.greater) begin
                    o_cmd.shift = 1'b1;
                    n_state     = S_SCAN;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                n_state = i_stat.last ? S_MED0 : S_IDLE;
            end
            S_MED0: begin
                o_cmd.rd_hi = 1'b1;
                n_state     = S_MED1;
            end
            S_MED1: begin
                o_cmd.cap_hi = 1'b1;
                o_cmd.rd_lo  = 1'b1;
                n_state      = S_MED2;
            end
            S_MED2: begin
                if (!i_stat.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `MOLS_ASSERT(a_cmp_after_scan, i_clk, i_rst_n, (r_state == S_CMP) |-> ($past(r_state) == S_SCAN))
    `MOLS_ASSERT(a_med_after_done, i_clk, i_rst_n, $rose(r_state == S_MED0) |-> $past(i_stat.last))
    `MOLS_ASSERT(a_state_onehot, i_clk, i_rst_n, $onehot(r_state))
endmodule
